>>> rtl/core/chkv_pkg.sv
package chkv_pkg;
  localparam int KeyBytes    = 16;
  localparam int MaxBuckets  = 256;
  localparam int PoolEntries = 256;
  localparam int BktW        = $clog2(MaxBuckets);
  localparam int PoolW       = $clog2(PoolEntries);
  localparam int CntW        = PoolW + 1;
  localparam int KeyW        = 8 * KeyBytes;
  localparam int ByteIdxW    = $clog2(KeyBytes + 1);
  localparam logic [63:0] FnvBasis = 64'd1469598103934665603;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;

  typedef enum logic [2:0] {
    StMiss     = 3'd0,
    StHit      = 3'd1,
    StInserted = 3'd2,
    StReplaced = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SHash,
    SMulLo,
    SMulHi,
    SMod,
    SHead,
    SRead,
    SCmp,
    SWrite,
    SOut
  } state_e;

  // hash core sequencer
  typedef enum logic [2:0] {HIdle, HByte, HM0, HM1, HM2, HMod, HDone} hash_state_e;

  // control towards the hash core
  typedef struct packed {
    logic start;
  } hash_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hash_stat_t;
endpackage

>>> rtl/core/chkv_hash.sv
// byte-serial fnv-1a style hash on one 32x32 multiplier, then a bit-serial modulo
module chkv_hash (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  chkv_pkg::hash_ctrl_t    ctrl_i,
  input  logic [chkv_pkg::KeyW-1:0] key_i,
  input  logic [8:0]              div_i,
  output chkv_pkg::hash_stat_t    stat_o,
  output logic [chkv_pkg::BktW-1:0] bucket_o
);
  import chkv_pkg::*;

  hash_state_e hst_q, hst_d;
  logic [63:0] h_q, h_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [ByteIdxW-1:0] bi_q, bi_d;
  logic [6:0] bit_q, bit_d;
  logic [9:0] rem_q, rem_d;
  logic [7:0] cur_byte;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [9:0] rem_sh;

  assign cur_byte = key_i[8*bi_q[ByteIdxW-2:0] +: 8];
  assign mul_p    = mul_a * mul_b;
  assign rem_sh   = {rem_q[8:0], h_q[6'(bit_q - 7'd1)]};

  always_comb begin
    unique case (hst_q)
      HM0:     begin mul_a = x_q[31:0];  mul_b = FnvPrime[31:0];  end
      HM1:     begin mul_a = x_q[63:32]; mul_b = FnvPrime[31:0];  end
      default: begin mul_a = x_q[31:0];  mul_b = FnvPrime[63:32]; end
    endcase
  end

  always_comb begin
    hst_d = hst_q; h_d = h_q; x_d = x_q; acc_d = acc_q;
    bi_d = bi_q; bit_d = bit_q; rem_d = rem_q;
    unique case (hst_q)
      HIdle: if (ctrl_i.start) begin
        hst_d = HByte; h_d = FnvBasis; bi_d = '0;
      end
      HByte: begin
        if (bi_q == ByteIdxW'(KeyBytes) || cur_byte == 8'd0) begin
          hst_d = HMod; bit_d = 7'd64; rem_d = '0;
        end else begin
          x_d = h_q ^ {56'd0, cur_byte};
          hst_d = HM0;
        end
      end
      HM0: begin acc_d = mul_p; hst_d = HM1; end
      HM1: begin acc_d = acc_q + {mul_p[31:0], 32'd0}; hst_d = HM2; end
      HM2: begin
        h_d = acc_q + {mul_p[31:0], 32'd0};
        bi_d = bi_q + ByteIdxW'(1);
        hst_d = HByte;
      end
      HMod: begin
        rem_d = (rem_sh >= {1'b0, div_i}) ? rem_sh - {1'b0, div_i} : rem_sh;
        bit_d = bit_q - 7'd1;
        if (bit_q == 7'd1) hst_d = HDone;
      end
      default: hst_d = HIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q <= HIdle;
    end else begin
      hst_q <= hst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; x_q <= x_d; acc_q <= acc_d;
    bi_q <= bi_d; bit_q <= bit_d; rem_q <= rem_d;
  end

  assign stat_o.busy = (hst_q != HIdle);
  assign stat_o.done = (hst_q == HDone);
  assign bucket_o    = rem_q[BktW-1:0];

  a_rem_lt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> ({1'b0, rem_q} < {1'b0, div_i}))
    else $error("remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> !stat_o.done)
    else $error("done held");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.start && hst_q == HIdle) |=> hst_q == HByte)
    else $error("start lost");
endmodule

>>> rtl/core/chained_hash_key_value_table.sv
// Chained hash key-value table. Each input beat is a get (kind 0) or put (kind 1) with
// a 16-byte key (ends at the first zero byte) and a 32-bit value. The key is hashed
// byte by byte with a 64-bit fnv-1a style hash (fnv prime, nonstandard offset basis)
// on one shared 32x32 multiplier, reduced modulo the bucket count (clamped to 1..256) by a
// bit-serial divider, then the chain is walked, reading and comparing each entry visited.
// s_axis_tready stays low from acceptance until the result has been taken. The result is
// held in an output register. Configuration beats are taken only while the table is idle.
// Bucket heads carry valid bits cleared at reset, so no clearing pass is needed.
module chained_hash_key_value_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [8:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // key_low, key_high, value_in
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata   // status, value_out, bucket_index, entry_count, pad
);
  import chkv_pkg::*;

  state_e st_q, st_d;
  logic [8:0] bcnt_q;
  logic [8:0] div;
  logic kind_q;
  logic [KeyW-1:0] key_q;
  logic [31:0] vin_q;
  logic [BktW-1:0] bkt_q;
  logic [CntW-1:0] used_q;
  logic [PoolW-1:0] cur_q;
  logic have_q;
  logic found_q;
  logic [2:0] status_q;
  logic [31:0] vout_q;
  logic [MaxBuckets-1:0] hvalid_q;
  logic [PoolW-1:0] head_mem [MaxBuckets];
  logic [KeyW-1:0] ekey_mem [PoolEntries];
  logic [31:0] eval_mem [PoolEntries];
  logic [PoolW:0] enext_mem [PoolEntries];
  logic [KeyW-1:0] rkey_q;
  logic [31:0] rval_q;
  logic [PoolW:0] rnext_q;
  logic [PoolW-1:0] rhead_q;
  logic [KeyW-1:0] tkey;
  logic ended;
  hash_ctrl_t hctrl;
  hash_stat_t hstat;
  logic [BktW-1:0] hbkt;
  logic accept;

  // zero bytes from the first terminator on
  always_comb begin
    ended = 1'b0;
    tkey = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (s_axis_tdata[8*i +: 8] == 8'd0) ended = 1'b1;
      if (!ended) tkey[8*i +: 8] = s_axis_tdata[8*i +: 8];
    end
  end

  assign div = (bcnt_q == 9'd0) ? 9'd1 : (bcnt_q > 9'(MaxBuckets)) ? 9'(MaxBuckets) : bcnt_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == SIdle);
  assign cfg_ready_o = (st_q == SIdle);
  assign hctrl.start = (st_q == SHash) && !hstat.busy;

  chkv_hash u_hash (
    .clk_i, .rst_ni, .ctrl_i(hctrl), .key_i(key_q), .div_i(div),
    .stat_o(hstat), .bucket_o(hbkt)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle:  if (accept) st_d = SHash;
      SHash:  if (hstat.done) st_d = SHead;
      SHead:  st_d = SMod;
      SMod:   st_d = have_q ? SRead : SWrite;
      SRead:  st_d = SCmp;
      SCmp:   st_d = (rkey_q == key_q || !rnext_q[PoolW]) ? SWrite : SRead;
      SWrite: st_d = SOut;
      SOut:   if (m_axis_tready) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      bcnt_q <= 9'd256;
      hvalid_q <= '0;
      used_q <= '0;
      have_q <= 1'b0;
      found_q <= 1'b0;
      bkt_q <= '0;
      cur_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) bcnt_q <= cfg_data_i;
      unique case (st_q)
        SIdle: found_q <= 1'b0;
        SHash: if (hstat.done) bkt_q <= hbkt;
        SHead: have_q <= hvalid_q[bkt_q];
        SMod:  cur_q <= rhead_q;
        SCmp: begin
          if (rkey_q == key_q) found_q <= 1'b1;
          else cur_q <= rnext_q[PoolW-1:0];
        end
        SWrite: begin
          if (!found_q && kind_q && used_q < CntW'(PoolEntries)) begin
            hvalid_q[bkt_q] <= 1'b1;
            used_q <= used_q + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser;
      key_q <= tkey;
      vin_q <= s_axis_tdata[159:128];
    end
    rhead_q <= head_mem[bkt_q];
    rkey_q <= ekey_mem[cur_q];
    rval_q <= eval_mem[cur_q];
    rnext_q <= enext_mem[cur_q];
    if (st_q == SWrite) begin
      if (!kind_q) begin
        status_q <= found_q ? StHit : StMiss;
        vout_q <= found_q ? rval_q : 32'd0;
      end else if (found_q) begin
        status_q <= StReplaced;
        vout_q <= rval_q;
        eval_mem[cur_q] <= vin_q;
      end else if (used_q >= CntW'(PoolEntries)) begin
        status_q <= StFull;
        vout_q <= vin_q;
      end else begin
        status_q <= StInserted;
        vout_q <= 32'd0;
        ekey_mem[used_q[PoolW-1:0]] <= key_q;
        eval_mem[used_q[PoolW-1:0]] <= vin_q;
        enext_mem[used_q[PoolW-1:0]] <= {hvalid_q[bkt_q], rhead_q};
        head_mem[bkt_q] <= used_q[PoolW-1:0];
      end
    end
  end

  assign m_axis_tvalid = (st_q == SOut);
  assign m_axis_tdata = {4'd0, used_q, bkt_q, vout_q, status_q};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");
  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(PoolEntries))
    else $error("pool overflow");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("ready while busy");
endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import chkv_pkg::*;

  localparam int IdleLimit = 8000;
  localparam int HoldCycles = 600;

  typedef struct {
    logic [2:0]  st;
    logic [31:0] val;
    logic [7:0]  bkt;
    logic [8:0]  cnt;
  } lookup_res_t;

  typedef struct {
    logic        kind;
    logic [63:0] klo;
    logic [63:0] khi;
    logic [31:0] vin;
    bit          typed;
    status_e     st;
    logic [31:0] val;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [8:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [159:0] s_axis_tdata;  // key_low, key_high, value_in
  logic s_axis_tuser;          // kind
  logic m_axis_tvalid, m_axis_tready;
  logic [55:0] m_axis_tdata;   // status, value_out, bucket_index, entry_count, pad

  chained_hash_key_value_table dut (.*);

  // predictor state
  logic [8:0]  bucket_sel;
  bit          head_ok [MaxBuckets];
  logic [8:0]  head_at [MaxBuckets];
  logic [63:0] pool_lo [PoolEntries];
  logic [63:0] pool_hi [PoolEntries];
  logic [31:0] pool_val [PoolEntries];
  bit          link_ok [PoolEntries];
  logic [8:0]  link_at [PoolEntries];
  int          used_entries;

  lookup_res_t pending_q[$];
  logic [127:0] known_key_q[$];
  int          known_len_q[$];
  int          status_seen [5];
  int          fails, beats_in, beats_out, idle_mode, idle_run;
  bit          hold_req;
  int          hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic table_step(input logic kind, input logic [63:0] klo_raw,
                            input logic [63:0] khi_raw, input logic [31:0] vin,
                            output lookup_res_t r);
    logic [127:0] raw, trimmed;
    logic [63:0] h, div;
    logic [7:0] b;
    bit ended, hit, more;
    int cur, idx, steps;
    raw = {khi_raw, klo_raw};
    trimmed = '0;
    h = FnvBasis;
    ended = 0;
    for (int i = 0; i < KeyBytes; i++) begin
      b = raw[8*i +: 8];
      if (b == 8'd0) ended = 1;
      if (!ended) begin
        h = (h ^ {56'd0, b}) * FnvPrime;
        trimmed[8*i +: 8] = b;
      end
    end
    div = (bucket_sel == 0) ? 64'd1 : (bucket_sel > MaxBuckets) ? 64'(MaxBuckets) :
          64'(bucket_sel);
    idx = int'(h % div);
    hit = 0;
    more = head_ok[idx];
    cur = head_at[idx];
    steps = 0;
    while (more && !hit && steps < PoolEntries) begin
      if (pool_lo[cur] == trimmed[63:0] && pool_hi[cur] == trimmed[127:64]) hit = 1;
      else begin
        more = link_ok[cur];
        cur = link_at[cur];
      end
      steps++;
    end
    r.st = StMiss;
    r.val = '0;
    if (!kind) begin
      if (hit) begin
        r.st = StHit;
        r.val = pool_val[cur];
      end
    end else if (hit) begin
      r.st = StReplaced;
      r.val = pool_val[cur];
      pool_val[cur] = vin;
    end else if (used_entries >= PoolEntries) begin
      r.st = StFull;
      r.val = vin;
    end else begin
      pool_lo[used_entries] = trimmed[63:0];
      pool_hi[used_entries] = trimmed[127:64];
      pool_val[used_entries] = vin;
      link_ok[used_entries] = head_ok[idx];
      link_at[used_entries] = head_at[idx];
      head_ok[idx] = 1;
      head_at[idx] = 9'(used_entries);
      used_entries++;
      r.st = StInserted;
    end
    r.bkt = 8'(idx);
    r.cnt = 9'(used_entries);
  endtask

  // drive one beat and record what the table should answer
  task automatic put_beat(input logic kind, input logic [63:0] klo, input logic [63:0] khi,
                          input logic [31:0] vin, output lookup_res_t r);
    if ((idle_mode == 1 || idle_mode == 3) &&
        $urandom_range(99) < (idle_mode == 1 ? 45 : 13)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {vin, khi, klo};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_in++;
    table_step(kind, klo, khi, vin, r);
  endtask

  task automatic send_item(input logic kind, input logic [63:0] klo, input logic [63:0] khi,
                           input logic [31:0] vin);
    lookup_res_t r;
    put_beat(kind, klo, khi, vin, r);
    pending_q.push_back(r);
  endtask

  task automatic set_buckets(input logic [8:0] v);
    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bucket_sel = v;
  endtask

  // trimmed key of len bytes and, when shorter than a full key, a zero terminator then junk that must be ignored
  function automatic logic [127:0] dress_key(input logic [127:0] trimmed, input int len);
    logic [127:0] k;
    k = trimmed;
    for (int i = len + 1; i < KeyBytes; i++) k[8*i +: 8] = 8'($urandom);
    return k;
  endfunction

  task automatic random_item();
    logic [127:0] trimmed;
    int len, pick;
    if (known_key_q.size() > 0 && $urandom_range(99) < 55) begin
      pick = $urandom_range(known_key_q.size() - 1);
      trimmed = known_key_q[pick];
      len = known_len_q[pick];
    end else begin
      len = ($urandom_range(9) == 0) ? KeyBytes : $urandom_range(0, KeyBytes - 1);
      trimmed = '0;
      for (int i = 0; i < len; i++) trimmed[8*i +: 8] = 8'($urandom_range(1, 255));
      known_key_q.push_back(trimmed);
      known_len_q.push_back(len);
    end
    trimmed = dress_key(trimmed, len);
    send_item(1'($urandom), trimmed[63:0], trimmed[127:64], $urandom);
  endtask

  dir_row_t dir_rows[] = '{
    '{1'b0, 64'h0, 64'h0, 32'h0, 1, StMiss, 32'h0},
    '{1'b1, 64'h0, 64'h0, 32'h12345678, 1, StInserted, 32'h0},
    '{1'b0, 64'h0, '1, 32'h0, 1, StHit, 32'h12345678},
    '{1'b1, 64'hffff_ffff_ffff_ff00, '1, '1, 1, StReplaced, 32'h12345678},
    '{1'b1, '1, '1, 32'h0, 1, StInserted, 32'h0},
    '{1'b0, '1, '1, 32'h0, 1, StHit, 32'h0},
    '{1'b1, '1, '1, '1, 1, StReplaced, 32'h0},
    '{1'b1, 64'h0000_0000_0000_4241, 64'h0, 32'h5, 1, StInserted, 32'h0},
    '{1'b0, 64'hdead_beef_0000_4241, 64'h1, 32'h0, 1, StHit, 32'h5},
    '{1'b1, 64'h0807_0605_0403_0201, 64'hff00, 32'h8000_0001, 0, StMiss, 32'h0},
    '{1'b0, 64'h0807_0605_0403_0201, 64'h0, 32'h0, 0, StMiss, 32'h0},
    '{1'b0, 64'h0807_0605_0403_0201, 64'h0f0e_0d0c_0b0a_0900, 32'h0, 0, StMiss, 32'h0},
    '{1'b1, 64'h0102_0304_0506_0708, 64'h7f80_0102_0304_0506, 32'h0, 0, StMiss, 32'h0},
    '{1'b0, 64'h0102_0304_0506_0708, 64'h7f80_0102_0304_0506, 32'h0, 0, StMiss, 32'h0},
    '{1'b0, 64'h0000_0000_0000_0041, 64'h0, 32'h0, 1, StMiss, 32'h0}
  };

  logic [8:0] phase_buckets[8] = '{9'd1, 9'd0, 9'd511, 9'd256, 9'd7, 9'd3, 9'd255, 9'd256};

  initial begin
    lookup_res_t r;
    rst_ni = 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    hold_req = 0;
    idle_mode = 0;
    fails = 0;
    bucket_sel = 9'd256;
    used_entries = 0;
    for (int i = 0; i < MaxBuckets; i++) begin
      head_ok[i] = 0;
      head_at[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      put_beat(dir_rows[i].kind, dir_rows[i].klo, dir_rows[i].khi, dir_rows[i].vin, r);
      if (dir_rows[i].typed) begin
        r.st = dir_rows[i].st;
        r.val = dir_rows[i].val;
      end
      pending_q.push_back(r);
    end

    for (int ph = 0; ph < 8; ph++) begin
      set_buckets(ph == 6 ? 9'($urandom_range(2, 255)) : phase_buckets[ph]);
      idle_mode = ph % 4;
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 10) hold_req = 1;
        if (ph == 5 && n == 50) begin
          s_axis_tvalid <= 1'b0;
          wait (pending_q.size() == 0);
          @(posedge clk_i);
        end
        random_item();
      end
    end
    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (800) @(posedge clk_i);

    $display("%0d lookups and inserts sent, %0d results checked, pool holds %0d entries",
             beats_in, beats_out, used_entries);
    $display("statuses: miss %0d hit %0d inserted %0d replaced %0d full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req && hold_cnt < HoldCycles) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      if (hold_cnt >= HoldCycles) begin
        hold_req <= 0;
        hold_cnt <= 0;
      end
      case (idle_mode)
        2: m_axis_tready <= ($urandom_range(99) >= 45);
        3: m_axis_tready <= ($urandom_range(99) >= 13);
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    lookup_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing outstanding: %h", m_axis_tdata);
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[2:0] <= 3'd4) status_seen[m_axis_tdata[2:0]]++;
        if (m_axis_tdata[2:0] !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, m_axis_tdata[2:0]);
          fails++;
        end
        if (m_axis_tdata[34:3] !== e.val) begin
          $error("value_out: expected %h, got %h", e.val, m_axis_tdata[34:3]);
          fails++;
        end
        if (m_axis_tdata[42:35] !== e.bkt) begin
          $error("bucket_index: expected %0d, got %0d", e.bkt, m_axis_tdata[42:35]);
          fails++;
        end
        if (m_axis_tdata[51:43] !== e.cnt) begin
          $error("entry_count: expected %0d, got %0d", e.cnt, m_axis_tdata[51:43]);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_run <= 0;
    end else if (idle_run >= IdleLimit) begin
      $display("timeout: no beat for %0d cycles", idle_run);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end
endmodule

>>> sim.f
rtl/core/chkv_pkg.sv
rtl/core/chkv_hash.sv
rtl/core/chained_hash_key_value_table.sv
tb/testbench.sv
